// ===== hdl/ils_pkg.sv =====
// ils_pkg: shared types, constants and helper functions for the
// intersection light sequencer; no dependencies
package ils_pkg;

    localparam int MAX_WAYS  = 4;
    localparam int WAY_W     = $clog2(MAX_WAYS);
    localparam int LEN_W     = 10;
    localparam int COUNT_W   = 3;
    localparam int COLOR_W   = 2;
    localparam int IDX_W     = 3;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 24;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [WAY_W-1:0]   way_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam color_t COL_GREEN  = 2'd0;
    localparam color_t COL_YELLOW = 2'd1;
    localparam color_t COL_RED    = 2'd2;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_WAY_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_GREEN_0   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GREEN_1   = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_2   = 3'd3;
    localparam logic [IDX_W-1:0] REG_GREEN_3   = 3'd4;
    localparam logic [IDX_W-1:0] REG_YELLOW    = 3'd5;

    localparam count_t RST_WAY_COUNT = 3'd2;
    localparam len_t   RST_GREEN_LEN = 10'd60;
    localparam len_t   RST_YELLOW_LEN = 10'd10;

    typedef struct packed {
        count_t               way_count;
        logic [3:0][LEN_W-1:0] green_len;
        len_t                 yellow_len;
    } cfg_t;

    typedef struct packed {
        color_t [3:0] light;
        way_t         active_way;
        logic         changed;
        len_t         ticks_left;
    } result_t;

    // green -> yellow -> red -> green
    function automatic color_t next_color(color_t c);
        color_t n;
        if (c == COL_GREEN) begin
            n = COL_YELLOW;
        end else if (c == COL_YELLOW) begin
            n = COL_RED;
        end else begin
            n = COL_GREEN;
        end
        return n;
    endfunction

    // phase length to counter reload, zero acts as one
    function automatic len_t reload(len_t len);
        len_t r;
        r = (len == '0) ? '0 : len - len_t'(1);
        return r;
    endfunction

    // clamp the way count into 2..MAX_WAYS
    function automatic count_t eff_count(count_t c);
        count_t r;
        if (c < count_t'(2)) begin
            r = count_t'(2);
        end else if (c > count_t'(MAX_WAYS)) begin
            r = count_t'(MAX_WAYS);
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

// ===== hdl/intersection_light_sequencer.sv =====
// intersection_light_sequencer: top level, round robin traffic light sequencer for up to
// four approaches; depends on ils_pkg, ils_cfg_regs, ils_phase_ctrl and ils_out_reg
// result: the result word of an accepted tick word is registered and shown in the next cycle
// throughput: one word per cycle; input is ready whenever the result register is empty
//   or is being drained in the same cycle
// reset: async, active low; all lights red, approach 0 active, countdown zero, registers
//   back to way count 2, green 60, yellow 10; the first advancing tick greens approach 0
module intersection_light_sequencer
    import ils_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tick stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] advance, rest zero
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] light_0, [3:2] light_1, [5:4] light_2, [7:6] light_3,
    // [9:8] active_way, [10] changed, [20:11] ticks_left, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [LEN_W-1:0]      cfg_data
);

    cfg_t    cfg;
    result_t result;
    logic    accept;

    // a new tick may enter while the previous result is being taken
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // register file for way count and phase lengths
    ils_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // light state and countdown, updated on every accepted word
    ils_phase_ctrl u_phase_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .advance (s_axis_tdata[0]),
        .result  (result)
    );

    // result word holding register
    ils_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .result        (result),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== hdl/ils_cfg_regs.sv =====
// ils_cfg_regs: configuration register file written through the cfg port
// depends on ils_pkg
module ils_cfg_regs
    import ils_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.way_count  <= RST_WAY_COUNT;
            cfg_reg.green_len  <= {4{RST_GREEN_LEN}};
            cfg_reg.yellow_len <= RST_YELLOW_LEN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAY_COUNT: cfg_reg.way_count    <= cfg_data[COUNT_W-1:0];
                REG_GREEN_0:   cfg_reg.green_len[0] <= cfg_data;
                REG_GREEN_1:   cfg_reg.green_len[1] <= cfg_data;
                REG_GREEN_2:   cfg_reg.green_len[2] <= cfg_data;
                REG_GREEN_3:   cfg_reg.green_len[3] <= cfg_data;
                REG_YELLOW:    cfg_reg.yellow_len   <= cfg_data;
                default:       ;  // unmapped index, ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/ils_phase_ctrl.sv =====
// ils_phase_ctrl: light colors, active approach and countdown, stepped one
// tick per accepted word with the advance bit set; depends on ils_pkg
module ils_phase_ctrl
    import ils_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    accept,
    input  logic    advance,
    output result_t result
);

    color_t [MAX_WAYS-1:0] colors_reg, colors_next;
    way_t                  way_reg, way_next;
    len_t                  cnt_reg, cnt_next;
    logic                  event_hit;
    count_t                count;
    color_t                cur_next;
    logic [COUNT_W-1:0]    succ;

    assign count = eff_count(cfg.way_count);

    always_comb
    begin
        colors_next = colors_reg;
        way_next    = way_reg;
        cnt_next    = cnt_reg;
        event_hit   = 1'b0;
        cur_next    = next_color(colors_reg[way_reg]);
        // successor approach, (way + 1) mod count with two folds
        succ = COUNT_W'(way_reg) + COUNT_W'(1);
        if (succ >= count)
        begin
            succ = succ - count;
        end
        if (succ >= count)
        begin
            succ = succ - count;
        end
        if (advance)
        begin
            if (cnt_reg == '0)
            begin
                event_hit = 1'b1;
                colors_next[way_reg] = cur_next;
                if (cur_next == COL_YELLOW)
                begin
                    cnt_next = reload(cfg.yellow_len);
                end
                else if (cur_next == COL_RED)
                begin
                    // hand over right of way, next approach goes green
                    way_next = succ[WAY_W-1:0];
                    colors_next[succ[WAY_W-1:0]] =
                        next_color(colors_reg[succ[WAY_W-1:0]]);
                    cnt_next = reload(cfg.green_len[succ[WAY_W-1:0]]);
                end
                else
                begin
                    cnt_next = reload(cfg.green_len[way_reg]);
                end
            end
            else
            begin
                cnt_next = cnt_reg - len_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colors_reg <= {MAX_WAYS{COL_RED}};
            way_reg    <= '0;
            cnt_reg    <= '0;
        end
        else if (accept)
        begin
            colors_reg <= colors_next;
            way_reg    <= way_next;
            cnt_reg    <= cnt_next;
        end
    end

    // post-tick view; approaches beyond the count report red
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (count_t'(i) < count)
            begin
                result.light[i] = colors_next[i];
            end
            else
            begin
                result.light[i] = COL_RED;
            end
        end
        result.active_way = way_next;
        result.changed    = event_hit;
        result.ticks_left = cnt_next;
    end

endmodule

// ===== hdl/ils_out_reg.sv =====
// ils_out_reg: result register on the master-side stream
// depends on ils_pkg
module ils_out_reg
    import ils_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  result_t               result,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic                  valid_reg;
    logic [OUT_DATA_W-1:0] data_reg;
    logic [OUT_DATA_W-1:0] data_next;

    assign data_next = {3'b000,
                        result.ticks_left,
                        result.changed,
                        result.active_way,
                        result.light[3],
                        result.light[2],
                        result.light[1],
                        result.light[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule
